// File: src/ethtcp_pkg.sv
package ethtcp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_TCP_OK      = 3'd0,
    ST_BAD_IP_HDR  = 3'd1,
    ST_NOT_TCP     = 3'd2,
    ST_BAD_TCP_HDR = 3'd3,
    ST_TRUNCATED   = 3'd4
  } status_t;

  localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
  localparam logic [7:0] IP_PROTO_TCP  = 8'd6;

  // Byte offsets relative to the start of the IP header
  localparam int IP_PROTO_OFS = 9;
  localparam int IP_SRC_OFS   = 12;
  localparam int IP_DST_OFS   = 16;
  // Offset of the data offset byte inside the TCP header
  localparam int TCP_DOFF_OFS = 12;

  // One frame's captured fields plus classification flags
  typedef struct packed {
    logic        len_ip;     // ip header length byte arrived
    logic        len_proto;  // protocol byte arrived
    logic        len_tcp;    // tcp data offset byte arrived
    logic        ip_ok;      // ip header length >= 20
    logic        is_tcp;     // protocol == tcp
    logic        tcp_ok;     // tcp header length >= 20
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
  } frame_rec_t;

endpackage

// File: src/eth_ipv4_tcp_header_parser_unit.sv
// A frame's record is written into the record queue on the edge that takes its last byte,
// then moves to the output register that drives the out_ ports once that register is free.
// Throughput: one byte per cycle while in_full is low, down to back-to-back one-byte frames.
// Rate is set by the front capture path (one byte per clock) and the back output register.
// in_full rises only when the two-entry record queue is full, i.e. results are not popped.
// Reset (rst_n low, synchronous) clears the frame state, the queue, the output and tcp count.
module eth_ipv4_tcp_header_parser_unit #(
  parameter int MAX_FRAME_BYTES  = 2048,
  parameter int ETH_HEADER_BYTES = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input queue side
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_last,
  // result queue side
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [31:0] out_packet_number,
  output logic [31:0] out_src_ip,
  output logic [31:0] out_dst_ip,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [47:0] out_dst_mac,
  output logic [47:0] out_src_mac
);

  ethtcp_pkg::frame_rec_t wr_rec, rd_rec;
  logic byte_take, rec_push, q_full, q_empty, q_pop;

  // Every item is one frame byte; only a last byte pushes a record,
  // but stalling all bytes on a full queue keeps the front simple.
  assign in_full   = q_full;
  assign byte_take = in_push && !q_full;

  // Front: per-byte field capture and length / header classification
  ethtcp_front #(
    .MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
    .ETH_HEADER_BYTES (ETH_HEADER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_take),
    .frame_byte (in_frame_byte),
    .frame_last (in_frame_last),
    .rec_push   (rec_push),
    .rec        (wr_rec)
  );

  // Short record queue decoupling capture from result delivery
  ethtcp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (rec_push),
    .wr_rec (wr_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (rd_rec),
    .empty  (q_empty)
  );

  // Back: status decision, tcp packet count and the output register
  ethtcp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec           (rd_rec),
    .rec_empty     (q_empty),
    .rec_pop       (q_pop),
    .res_empty     (out_empty),
    .res_pop       (out_pop),
    .status        (out_status),
    .packet_number (out_packet_number),
    .src_ip        (out_src_ip),
    .dst_ip        (out_dst_ip),
    .src_port      (out_src_port),
    .dst_port      (out_dst_port),
    .dst_mac       (out_dst_mac),
    .src_mac       (out_src_mac)
  );

  // A record is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !rec_push)
    else $error("record pushed into full queue");

  // The back never idles with a waiting record and a free output slot
  a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && out_empty) |=> !out_empty)
    else $error("back stage stalled with free output");

  // The tcp count never moves while a result sits unpopped
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_packet_number))
    else $error("packet count changed under a held result");

endmodule

// File: src/ethtcp_front.sv
module ethtcp_front #(
  parameter int MAX_FRAME_BYTES  = 2048,
  parameter int ETH_HEADER_BYTES = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  input  logic [7:0]            frame_byte,
  input  logic                  frame_last,
  output logic                  rec_push,
  output ethtcp_pkg::frame_rec_t rec
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_ETH = POS_W'(ETH_HEADER_BYTES);

  logic [POS_W-1:0] pos_r, len;
  logic [5:0]       ihl_r, ihl_nxt, thl_r, thl_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [47:0]      dmac_r, dmac_nxt, smac_r, smac_nxt;
  logic [31:0]      sip_r, sip_nxt, dip_r, dip_nxt;
  logic [15:0]      sport_r, sport_nxt, dport_r, dport_nxt;
  logic             cap, tcp_zone;
  logic [POS_W-1:0] tcp_base, tofs;

  always_comb begin
    cap       = pos_r < POS_MAX;
    len       = cap ? pos_r + POS_W'(1) : POS_MAX;
    dmac_nxt  = dmac_r;
    smac_nxt  = smac_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    ihl_nxt   = ihl_r;
    thl_nxt   = thl_r;
    proto_nxt = proto_r;
    tcp_base  = POS_ETH + POS_W'(ihl_r);
    tofs      = pos_r - tcp_base;
    tcp_zone  = (ihl_r >= ethtcp_pkg::MIN_HDR_BYTES) && (pos_r >= tcp_base);
    if (cap) begin
      for (int i = 0; i < 6; i++) begin
        if (pos_r == POS_W'(i)) dmac_nxt[8*(5-i) +: 8] = frame_byte;
        if (pos_r == POS_W'(i + 6)) smac_nxt[8*(5-i) +: 8] = frame_byte;
      end
      for (int i = 0; i < 4; i++) begin
        if (pos_r == POS_W'(ETH_HEADER_BYTES + ethtcp_pkg::IP_SRC_OFS + i))
          sip_nxt[8*(3-i) +: 8] = frame_byte;
        if (pos_r == POS_W'(ETH_HEADER_BYTES + ethtcp_pkg::IP_DST_OFS + i))
          dip_nxt[8*(3-i) +: 8] = frame_byte;
      end
      if (pos_r == POS_ETH) ihl_nxt = {frame_byte[3:0], 2'b00};
      if (pos_r == POS_W'(ETH_HEADER_BYTES + ethtcp_pkg::IP_PROTO_OFS)) proto_nxt = frame_byte;
      if (tcp_zone) begin
        if (tofs == POS_W'(0)) sport_nxt[15:8] = frame_byte;
        if (tofs == POS_W'(1)) sport_nxt[7:0]  = frame_byte;
        if (tofs == POS_W'(2)) dport_nxt[15:8] = frame_byte;
        if (tofs == POS_W'(3)) dport_nxt[7:0]  = frame_byte;
        if (tofs == POS_W'(ethtcp_pkg::TCP_DOFF_OFS)) thl_nxt = {frame_byte[7:4], 2'b00};
      end
    end
  end

  // Record built from the state including the final byte
  always_comb begin
    rec_push      = byte_valid && frame_last;
    rec.len_ip    = len >= POS_W'(ETH_HEADER_BYTES + 1);
    rec.len_proto = len >= POS_W'(ETH_HEADER_BYTES + ethtcp_pkg::IP_PROTO_OFS + 1);
    rec.len_tcp   = len >= POS_ETH + POS_W'(ihl_nxt) + POS_W'(ethtcp_pkg::TCP_DOFF_OFS + 1);
    rec.ip_ok     = ihl_nxt >= ethtcp_pkg::MIN_HDR_BYTES;
    rec.is_tcp    = proto_nxt == ethtcp_pkg::IP_PROTO_TCP;
    rec.tcp_ok    = thl_nxt >= ethtcp_pkg::MIN_HDR_BYTES;
    rec.src_ip    = sip_nxt;
    rec.dst_ip    = dip_nxt;
    rec.src_port  = sport_nxt;
    rec.dst_port  = dport_nxt;
    rec.dst_mac   = dmac_nxt;
    rec.src_mac   = smac_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_valid && frame_last)) begin
      pos_r   <= '0;
      ihl_r   <= '0;
      thl_r   <= '0;
      proto_r <= '0;
      dmac_r  <= '0;
      smac_r  <= '0;
      sip_r   <= '0;
      dip_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
    end else if (byte_valid) begin
      pos_r   <= len;
      ihl_r   <= ihl_nxt;
      thl_r   <= thl_nxt;
      proto_r <= proto_nxt;
      dmac_r  <= dmac_nxt;
      smac_r  <= smac_nxt;
      sip_r   <= sip_nxt;
      dip_r   <= dip_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
    end
  end

endmodule

// File: src/ethtcp_queue.sv
module ethtcp_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ethtcp_pkg::frame_rec_t wr_rec,
  output logic                   full,
  input  logic                   pop,
  output ethtcp_pkg::frame_rec_t rd_rec,
  output logic                   empty
);

  // Two-entry shift queue: head is always the oldest record
  ethtcp_pkg::frame_rec_t head_r, head_nxt, tail_r, tail_nxt;
  logic head_v_r, head_v_nxt, tail_v_r, tail_v_nxt;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    if (pop) begin
      if (tail_v_r) begin
        head_nxt   = tail_r;
        tail_v_nxt = push;
        tail_nxt   = wr_rec;
      end else begin
        head_v_nxt = push;
        head_nxt   = wr_rec;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_v_nxt = 1'b1;
        head_nxt   = wr_rec;
      end else begin
        tail_v_nxt = 1'b1;
        tail_nxt   = wr_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign full   = tail_v_r;
  assign empty  = !head_v_r;
  assign rd_rec = head_r;

endmodule

// File: src/ethtcp_back.sv
module ethtcp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ethtcp_pkg::frame_rec_t rec,
  input  logic                   rec_empty,
  output logic                   rec_pop,
  output logic                   res_empty,
  input  logic                   res_pop,
  output logic [2:0]             status,
  output logic [31:0]            packet_number,
  output logic [31:0]            src_ip,
  output logic [31:0]            dst_ip,
  output logic [15:0]            src_port,
  output logic [15:0]            dst_port,
  output logic [47:0]            dst_mac,
  output logic [47:0]            src_mac
);

  ethtcp_pkg::status_t    st;
  ethtcp_pkg::status_t    status_r;
  ethtcp_pkg::frame_rec_t rec_r;
  logic        res_v_r, counted;
  logic [31:0] count_r, count_nxt;

  // Checks in priority order; tcp count bumps once protocol is known tcp
  always_comb begin
    counted = 1'b0;
    if (!rec.len_ip)         st = ethtcp_pkg::ST_TRUNCATED;
    else if (!rec.ip_ok)     st = ethtcp_pkg::ST_BAD_IP_HDR;
    else if (!rec.len_proto) st = ethtcp_pkg::ST_TRUNCATED;
    else if (!rec.is_tcp)    st = ethtcp_pkg::ST_NOT_TCP;
    else begin
      counted = 1'b1;
      if (!rec.len_tcp)     st = ethtcp_pkg::ST_TRUNCATED;
      else if (!rec.tcp_ok) st = ethtcp_pkg::ST_BAD_TCP_HDR;
      else                  st = ethtcp_pkg::ST_TCP_OK;
    end
    rec_pop   = !rec_empty && (!res_v_r || res_pop);
    count_nxt = count_r + {31'd0, counted};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
      count_r <= '0;
    end else if (rec_pop) begin
      res_v_r <= 1'b1;
      count_r <= count_nxt;
    end else if (res_pop) begin
      res_v_r <= 1'b0;
    end
    if (rec_pop) begin
      status_r <= st;
      rec_r    <= rec;
    end
  end

  assign res_empty     = !res_v_r;
  assign status        = status_r;
  assign packet_number = count_r;
  assign src_ip        = rec_r.src_ip;
  assign dst_ip        = rec_r.dst_ip;
  assign src_port      = rec_r.src_port;
  assign dst_port      = rec_r.dst_port;
  assign dst_mac       = rec_r.dst_mac;
  assign src_mac       = rec_r.src_mac;

endmodule

// File: dv/tb_ethtcp_board_pkg.sv
`timescale 1ns / 100ps

package tb_ethtcp_board_pkg;

  localparam int ETH_BYTES = 14;
  localparam int MAX_BYTES = 2048;

  typedef struct packed {
    ethtcp_pkg::status_t status;
    logic [31:0] packet_number;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
  } hdr_result_t;

  // Header predictor plus the in-order store of expected frame results.
  class header_board;
    hdr_result_t want_q[$];
    int unsigned mismatches;

    int unsigned byte_pos;
    int unsigned ip_hdr_len;
    int unsigned tcp_hdr_len;
    logic [7:0]  proto;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] tcp_frames;

    function new();
      mismatches = 0;
      tcp_frames = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_pos    = 0;
      ip_hdr_len  = 0;
      tcp_hdr_len = 0;
      proto       = '0;
      dst_mac     = '0;
      src_mac     = '0;
      src_ip      = '0;
      dst_ip      = '0;
      src_port    = '0;
      dst_port    = '0;
    endfunction

    function string show(hdr_result_t r);
      return $sformatf("st=%0d pkt=%0d sip=%h dip=%h sport=%h dport=%h dmac=%h smac=%h",
                       r.status, r.packet_number, r.src_ip, r.dst_ip, r.src_port,
                       r.dst_port, r.dst_mac, r.src_mac);
    endfunction

    // One accepted byte; queues a result on the last byte of a frame.
    function void take_byte(logic [7:0] data, logic last);
      int unsigned pos;
      int unsigned len;
      int unsigned t;
      ethtcp_pkg::status_t st;
      hdr_result_t r;
      pos = byte_pos;
      if (pos < MAX_BYTES) begin
        if (pos < 6) dst_mac[8 * (5 - pos) +: 8] = data;
        else if (pos < 12) src_mac[8 * (11 - pos) +: 8] = data;
        if (pos == ETH_BYTES) ip_hdr_len = 4 * data[3:0];
        else if (pos == ETH_BYTES + ethtcp_pkg::IP_PROTO_OFS) proto = data;
        else if (pos >= ETH_BYTES + ethtcp_pkg::IP_SRC_OFS &&
                 pos < ETH_BYTES + ethtcp_pkg::IP_DST_OFS)
          src_ip[8 * (ETH_BYTES + ethtcp_pkg::IP_SRC_OFS + 3 - pos) +: 8] = data;
        else if (pos >= ETH_BYTES + ethtcp_pkg::IP_DST_OFS &&
                 pos < ETH_BYTES + ethtcp_pkg::IP_DST_OFS + 4)
          dst_ip[8 * (ETH_BYTES + ethtcp_pkg::IP_DST_OFS + 3 - pos) +: 8] = data;
        // tcp fields only once a usable ip header length is known
        if (ip_hdr_len >= ethtcp_pkg::MIN_HDR_BYTES && pos > ETH_BYTES &&
            pos >= ETH_BYTES + ip_hdr_len) begin
          t = pos - ETH_BYTES - ip_hdr_len;
          if (t < 2) src_port[8 * (1 - t) +: 8] = data;
          else if (t < 4) dst_port[8 * (3 - t) +: 8] = data;
          else if (t == ethtcp_pkg::TCP_DOFF_OFS) tcp_hdr_len = 4 * data[7:4];
        end
        len = pos + 1;
      end else begin
        len = MAX_BYTES;
      end

      if (!last) begin
        byte_pos = len;
        return;
      end

      if (len < ETH_BYTES + 1) st = ethtcp_pkg::ST_TRUNCATED;
      else if (ip_hdr_len < ethtcp_pkg::MIN_HDR_BYTES) st = ethtcp_pkg::ST_BAD_IP_HDR;
      else if (len < ETH_BYTES + ethtcp_pkg::IP_PROTO_OFS + 1) st = ethtcp_pkg::ST_TRUNCATED;
      else if (proto != ethtcp_pkg::IP_PROTO_TCP) st = ethtcp_pkg::ST_NOT_TCP;
      else begin
        tcp_frames++;
        if (len < ETH_BYTES + ip_hdr_len + ethtcp_pkg::TCP_DOFF_OFS + 1)
          st = ethtcp_pkg::ST_TRUNCATED;
        else if (tcp_hdr_len < ethtcp_pkg::MIN_HDR_BYTES) st = ethtcp_pkg::ST_BAD_TCP_HDR;
        else st = ethtcp_pkg::ST_TCP_OK;
      end

      r.status        = st;
      r.packet_number = tcp_frames;
      r.src_ip        = src_ip;
      r.dst_ip        = dst_ip;
      r.src_port      = src_port;
      r.dst_port      = dst_port;
      r.dst_mac       = dst_mac;
      r.src_mac       = src_mac;
      want_q.push_back(r);
      clear_frame();
    endfunction

    function void check_result(hdr_result_t got);
      hdr_result_t want;
      if (want_q.size() == 0) begin
        if (mismatches < 10) $display("ERROR: result with no frame pending: %s", show(got));
        mismatches++;
        return;
      end
      want = want_q.pop_front();
      if (got.status !== want.status || got.packet_number !== want.packet_number ||
          got.src_ip !== want.src_ip || got.dst_ip !== want.dst_ip ||
          got.src_port !== want.src_port || got.dst_port !== want.dst_port ||
          got.dst_mac !== want.dst_mac || got.src_mac !== want.src_mac) begin
        if (mismatches < 10) begin
          $display("ERROR: result mismatch at %0t", $time);
          $display("  exp %s", show(want));
          $display("  got %s", show(got));
        end
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: dv/tb_eth_ipv4_tcp_header_parser_unit.sv
`timescale 1ns / 100ps

module tb_eth_ipv4_tcp_header_parser_unit;

  // No-progress window; a correct run moves an item on one side or the
  // other well within it.
  localparam int STALL_LIMIT = 200;
  localparam int TOTAL_BYTES = 1150;
  localparam int ETH_BYTES   = tb_ethtcp_board_pkg::ETH_BYTES;
  localparam int MAX_BYTES   = tb_ethtcp_board_pkg::MAX_BYTES;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_push       = 1'b0;
  logic [7:0]  in_frame_byte = '0;
  logic        in_frame_last = 1'b0;
  logic        out_pop       = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [2:0]  out_status;
  logic [31:0] out_packet_number;
  logic [31:0] out_src_ip;
  logic [31:0] out_dst_ip;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [47:0] out_dst_mac;
  logic [47:0] out_src_mac;

  tb_ethtcp_board_pkg::header_board board;
  logic [7:0]  frame_bytes[$];   // frame under construction
  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          in_gaps;          // per-frame: allow gaps between bytes

  eth_ipv4_tcp_header_parser_unit #(
    .MAX_FRAME_BYTES (MAX_BYTES),
    .ETH_HEADER_BYTES(ETH_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_frame_byte    (in_frame_byte),
    .in_frame_last    (in_frame_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_packet_number(out_packet_number),
    .out_src_ip       (out_src_ip),
    .out_dst_ip       (out_dst_ip),
    .out_src_port     (out_src_port),
    .out_dst_port     (out_dst_port),
    .out_dst_mac      (out_dst_mac),
    .out_src_mac      (out_src_mac)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: any cycle that moves an item in either direction restarts it.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles at %0t", STALL_LIMIT, $time);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Fill the frame buffer with len bytes: random when fill < 0, else constant.
  function automatic void fill_frame(int len, int fill);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
  endfunction

  // One byte on the push side. The gap is drawn per item; push stays high
  // across back-to-back items so it never toggles within a time step.
  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = in_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_frame_byte <= data;
    in_frame_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.take_byte(data, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    // about a quarter of frames go through with no gaps at all
    in_gaps = ($urandom_range(0, 3) != 0);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Random frame with the header length nibble, protocol and (if ihl_nib >= 5)
  // tcp data offset nibble forced where the frame is long enough to hold them.
  // The ip version nibble and the low half of the data offset byte stay random.
  task automatic send_shaped(input int len, input int ihl_nib, input int proto,
                             input int doff_nib);
    int doff_pos;
    fill_frame(len, -1);
    doff_pos = ETH_BYTES + 4 * ihl_nib + ethtcp_pkg::TCP_DOFF_OFS;
    if (len > ETH_BYTES)
      frame_bytes[ETH_BYTES] = (frame_bytes[ETH_BYTES] & 8'hf0) | 8'(ihl_nib & 15);
    if (len > ETH_BYTES + ethtcp_pkg::IP_PROTO_OFS)
      frame_bytes[ETH_BYTES + ethtcp_pkg::IP_PROTO_OFS] = 8'(proto);
    if (ihl_nib >= 5 && len > doff_pos)
      frame_bytes[doff_pos] = (frame_bytes[doff_pos] & 8'h0f) | 8'((doff_nib & 15) << 4);
    send_frame();
  endtask

  // Pop side: random stalls per item, in bursts that are sometimes stall-free.
  task automatic take_results();
    tb_ethtcp_board_pkg::hdr_result_t got;
    int          stall;
    int          burst    = 0;
    bit          out_gaps = 1'b0;
    forever begin
      if (burst == 0) begin
        out_gaps = ($urandom_range(0, 3) != 0);
        burst    = $urandom_range(1, 16);
      end
      burst--;
      stall = out_gaps ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      got.status        = ethtcp_pkg::status_t'(out_status);
      got.packet_number = out_packet_number;
      got.src_ip        = out_src_ip;
      got.dst_ip        = out_dst_ip;
      got.src_port      = out_src_port;
      got.dst_port      = out_dst_port;
      got.dst_mac       = out_dst_mac;
      got.src_mac       = out_src_mac;
      board.check_result(got);
    end
  endtask

  initial begin
    int ihl;
    int doff;
    int full_len;
    int pick;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_results();
    join_none

    // ---- directed frames ----
    // single byte and header-less frames: truncated before the ip length
    fill_frame(1, 255);
    send_frame();
    fill_frame(ETH_BYTES, 255);
    send_frame();
    // length byte present but protocol missing, then protocol just present
    send_shaped(ETH_BYTES + 1, 5, ethtcp_pkg::IP_PROTO_TCP, 5);
    send_shaped(ETH_BYTES + ethtcp_pkg::IP_PROTO_OFS, 5, ethtcp_pkg::IP_PROTO_TCP, 5);
    send_shaped(ETH_BYTES + ethtcp_pkg::IP_PROTO_OFS + 1, 5, ethtcp_pkg::IP_PROTO_TCP, 5);
    // short ip header: ports are not captured even though bytes arrive
    send_shaped(60, 0, ethtcp_pkg::IP_PROTO_TCP, 5);
    send_shaped(60, 4, ethtcp_pkg::IP_PROTO_TCP, 5);
    // non-tcp protocols
    send_shaped(60, 5, 17, 5);
    send_shaped(60, 5, 255, 5);
    // minimal and maximal well-formed headers
    send_shaped(54, 5, ethtcp_pkg::IP_PROTO_TCP, 5);
    send_shaped(ETH_BYTES + 60 + 60, 15, ethtcp_pkg::IP_PROTO_TCP, 15);
    // short tcp header
    send_shaped(60, 5, ethtcp_pkg::IP_PROTO_TCP, 4);
    send_shaped(60, 5, ethtcp_pkg::IP_PROTO_TCP, 0);
    // data offset byte one short of arriving, then arriving as the last byte
    send_shaped(ETH_BYTES + 20 + ethtcp_pkg::TCP_DOFF_OFS, 5, ethtcp_pkg::IP_PROTO_TCP, 5);
    send_shaped(ETH_BYTES + 20 + ethtcp_pkg::TCP_DOFF_OFS + 1, 5,
                ethtcp_pkg::IP_PROTO_TCP, 5);
    send_shaped(ETH_BYTES + 60 + ethtcp_pkg::TCP_DOFF_OFS, 15, ethtcp_pkg::IP_PROTO_TCP, 5);
    send_shaped(ETH_BYTES + 60 + ethtcp_pkg::TCP_DOFF_OFS + 1, 15,
                ethtcp_pkg::IP_PROTO_TCP, 5);
    // all-zero and all-ones frames
    fill_frame(60, 0);
    send_frame();
    fill_frame(100, 255);
    send_frame();
    // consecutive single-byte frames, with or without gaps between them
    repeat (3) begin
      fill_frame(1, -1);
      send_frame();
    end

    // ---- random frames ----
    // Half are well-formed tcp headers with random content; the rest are
    // malformed, cut short or plain noise. Runs until the byte budget is spent.
    while (bytes_sent < TOTAL_BYTES) begin
      ihl      = ($urandom_range(0, 1) != 0) ? 5 : $urandom_range(5, 15);
      doff     = ($urandom_range(0, 1) != 0) ? 5 : $urandom_range(5, 15);
      full_len = ETH_BYTES + 4 * ihl +
                 $urandom_range(ethtcp_pkg::TCP_DOFF_OFS + 1, 4 * doff + 16);
      pick     = $urandom_range(0, 99);
      if (pick < 50) begin
        send_shaped(full_len, ihl, ethtcp_pkg::IP_PROTO_TCP, doff);
      end else if (pick < 60) begin
        send_shaped(full_len, $urandom_range(0, 4), ethtcp_pkg::IP_PROTO_TCP, doff);
      end else if (pick < 70) begin
        send_shaped(full_len, ihl, $urandom_range(0, 255), doff);
      end else if (pick < 80) begin
        send_shaped(full_len, ihl, ethtcp_pkg::IP_PROTO_TCP, $urandom_range(0, 4));
      end else if (pick < 92) begin
        send_shaped($urandom_range(1, full_len - 1), ihl, ethtcp_pkg::IP_PROTO_TCP, doff);
      end else begin
        fill_frame($urandom_range(1, 100), -1);
        send_frame();
      end
    end
    in_push <= 1'b0;

    // drain, then leave room for any stray result to show up
    while (board.want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
